// File: src/owvm_pkg.sv
// ----------------------------------------------------------------------------
// owvm_pkg: shared constants and table functions
// Register indexes, field widths and the octant sine/cosine generator.
// ----------------------------------------------------------------------------
package owvm_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 1'd1;

  localparam logic [11:0] DEAD_BAND_RST   = 12'd250;
  localparam logic [11:0] DRIVE_LIMIT_RST = 12'd3990;

  localparam logic [63:0] RAD_PER_TENTH_Q30 = 64'd1874033;
  localparam logic [63:0] ONE_Q30           = 64'd1073741824;
  localparam logic [25:0] TENTH_Q8          = 26'd26;

  localparam int LO_DEPTH = 256;
  localparam int HI_DEPTH = 195;

  typedef struct packed {
    logic [8:0] idx;
    logic       swap;
    logic [1:0] quad;
  } oct_sel_t;

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [15:0] to_q15(input logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

  function automatic logic [15:0] oct_sin(input int t);
    logic [63:0] x, x2, x3, x5, x7;
    x  = 64'(t) * RAD_PER_TENTH_Q30;
    x2 = qmul(x, x);
    x3 = qmul(x2, x);
    x5 = qmul(x3, x2);
    x7 = qmul(x5, x2);
    return to_q15(x + x5 / 64'd120 - x3 / 64'd6 - x7 / 64'd5040);
  endfunction

  function automatic logic [15:0] oct_cos(input int t);
    logic [63:0] x, x2, x4, x6, x8;
    x  = 64'(t) * RAD_PER_TENTH_Q30;
    x2 = qmul(x, x);
    x4 = qmul(x2, x2);
    x6 = qmul(x4, x2);
    x8 = qmul(x4, x4);
    return to_q15(ONE_Q30 + x4 / 64'd24 + x8 / 64'd40320 - x2 / 64'd2 - x6 / 64'd720);
  endfunction

endpackage

// File: src/owvm_sincos.sv
// ----------------------------------------------------------------------------
// owvm_sincos: two-stage sine/cosine of an angle in tenths of a degree
// Stage 1 folds to one octant, stage 2 reads the tables and applies signs.
// ----------------------------------------------------------------------------
module owvm_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic [11:0]        angle,
  output logic signed [15:0] sin_q15,
  output logic signed [15:0] cos_q15
);

  localparam int LO_DEPTH_L = owvm_pkg::LO_DEPTH;
  localparam int HI_DEPTH_L = owvm_pkg::HI_DEPTH;

  logic [15:0] sin_lo [LO_DEPTH_L];
  logic [15:0] cos_lo [LO_DEPTH_L];
  logic [15:0] sin_hi [HI_DEPTH_L];
  logic [15:0] cos_hi [HI_DEPTH_L];

  for (genvar g = 0; g < LO_DEPTH_L; g++) begin : g_lo
    assign sin_lo[g] = owvm_pkg::oct_sin(g);
    assign cos_lo[g] = owvm_pkg::oct_cos(g);
  end
  for (genvar g = 0; g < HI_DEPTH_L; g++) begin : g_hi
    assign sin_hi[g] = owvm_pkg::oct_sin(g + LO_DEPTH_L);
    assign cos_hi[g] = owvm_pkg::oct_cos(g + LO_DEPTH_L);
  end

  owvm_pkg::oct_sel_t sel, sel_next;
  logic [11:0] rem;

  always_comb begin
    if (angle >= 12'd2700) begin
      sel_next.quad = 2'd3;
      rem = angle - 12'd2700;
    end else if (angle >= 12'd1800) begin
      sel_next.quad = 2'd2;
      rem = angle - 12'd1800;
    end else if (angle >= 12'd900) begin
      sel_next.quad = 2'd1;
      rem = angle - 12'd900;
    end else begin
      sel_next.quad = 2'd0;
      rem = angle;
    end
    if (rem <= 12'd450) begin
      sel_next.idx  = rem[8:0];
      sel_next.swap = 1'b0;
    end else begin
      sel_next.idx  = 9'(12'd900 - rem);
      sel_next.swap = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) sel <= sel_next;
  end

  logic signed [15:0] a, b, sn, cs, sin_next, cos_next;

  always_comb begin
    if (sel.idx[8]) begin
      a = sin_hi[sel.idx[7:0]];
      b = cos_hi[sel.idx[7:0]];
    end else begin
      a = sin_lo[sel.idx[7:0]];
      b = cos_lo[sel.idx[7:0]];
    end
    sn = sel.swap ? b : a;
    cs = sel.swap ? a : b;
    case (sel.quad)
      2'd0: begin sin_next = sn;  cos_next = cs;  end
      2'd1: begin sin_next = cs;  cos_next = -sn; end
      2'd2: begin sin_next = -sn; cos_next = -cs; end
      default: begin sin_next = -cs; cos_next = sn; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q15 <= sin_next;
      cos_q15 <= cos_next;
    end
  end

endmodule

// File: src/owvm_wheel.sv
// ----------------------------------------------------------------------------
// owvm_wheel: three-stage wheel drive path
// Multiply, sum with magnitude, then offset and saturation.
// ----------------------------------------------------------------------------
module owvm_wheel (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] coef_x,
  input  logic signed [15:0] coef_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] turn_rate,
  input  logic               offset_enable,
  input  logic [11:0]        dead_band,
  input  logic [11:0]        drive_limit,
  output logic [11:0]        speed,
  output logic               reverse
);

  // stage A: products
  logic signed [31:0] px, py, pr;
  logic               offs_a;
  always_ff @(posedge clk) begin
    if (en) begin
      px     <= coef_x * vel_x;
      py     <= coef_y * vel_y;
      pr     <= 32'(turn_rate) <<< 15;
      offs_a <= offset_enable;
    end
  end

  // stage B: sum and magnitude
  logic signed [33:0] sum;
  logic [32:0]        mag, mag_next;
  logic               rev_b, offs_b;
  always_comb begin
    sum = 34'(px) + 34'(py) + 34'(pr);
    mag_next = (sum <= 0) ? 33'(-sum) : 33'(sum);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mag    <= mag_next;
      rev_b  <= (sum <= 0);
      offs_b <= offs_a;
    end
  end

  // stage C: dead-band offset and limit
  logic [18:0] val;
  always_comb begin
    val = 19'(mag[32:15]);
    if (offs_b && (mag[32:7] >= owvm_pkg::TENTH_Q8)) val = val + 19'(dead_band);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      speed   <= (val >= 19'(drive_limit)) ? drive_limit : val[11:0];
      reverse <= rev_b;
    end
  end

endmodule

// File: src/omni_wheel_velocity_mixer.sv
// ----------------------------------------------------------------------------
// omni_wheel_velocity_mixer: three-wheel omni inverse kinematics
// One transaction per cycle while the output is not stalled by out_ready.
// Rate is set by the six-stage pipeline: angle reduce, octant fold, table read,
// multiply, sum, offset/limit. A stall holds every stage in place.
// Reset (synchronous, active high) clears all valid bits and loads
// dead-band offset = 250 and drive_limit = 3990.
// ----------------------------------------------------------------------------
module omni_wheel_velocity_mixer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             vel_x,
  input  logic signed [15:0]             vel_y,
  input  logic signed [15:0]             turn_rate,
  input  logic signed [13:0]             heading_tenths,
  input  logic                           offset_enable,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [11:0]                    wheel0_speed,
  output logic                           wheel0_reverse,
  output logic [11:0]                    wheel1_speed,
  output logic                           wheel1_reverse,
  output logic [11:0]                    wheel2_speed,
  output logic                           wheel2_reverse,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [owvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                    cfg_data
);

  // whole pipe advances together; the output stage is the last register
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // config registers, always writable
  logic [11:0] dead_band, drive_limit;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band   <= owvm_pkg::DEAD_BAND_RST;
      drive_limit <= owvm_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == owvm_pkg::REG_DEAD_BAND)   dead_band   <= cfg_data;
      if (cfg_index == owvm_pkg::REG_DRIVE_LIMIT) drive_limit <= cfg_data;
    end
  end

  // valid bits, one per stage
  logic [5:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[4:0], in_valid};
  end
  assign out_valid = vld[5];

  // stage 1: heading modulo 3600, then the 60 degree offsets
  logic signed [15:0] h;
  logic [11:0] a_next, a0_next, a2_next, a1, a0, a2;
  logic [12:0] t0;
  logic signed [12:0] t2;
  always_comb begin
    h = 16'(heading_tenths);
    if (h < -16'sd7200)      a_next = 12'(h + 16'sd10800);
    else if (h < -16'sd3600) a_next = 12'(h + 16'sd7200);
    else if (h < 16'sd0)     a_next = 12'(h + 16'sd3600);
    else if (h < 16'sd3600)  a_next = 12'(h);
    else if (h < 16'sd7200)  a_next = 12'(h - 16'sd3600);
    else                     a_next = 12'(h - 16'sd7200);
    t0 = 13'(a_next) + 13'd600;
    a0_next = (t0 >= 13'd3600) ? 12'(t0 - 13'd3600) : t0[11:0];
    t2 = 13'sd600 - $signed({1'b0, a_next});
    a2_next = (t2 < 0) ? 12'(t2 + 13'sd3600) : 12'(t2);
  end

  logic signed [15:0] vx1, vy1, vr1, vx2, vy2, vr2, vx3, vy3, vr3;
  logic               of1, of2, of3;
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_next;  a0 <= a0_next;  a2 <= a2_next;
      vx1 <= vel_x;  vy1 <= vel_y;  vr1 <= turn_rate;  of1 <= offset_enable;
      vx2 <= vx1;    vy2 <= vy1;    vr2 <= vr1;        of2 <= of1;
      vx3 <= vx2;    vy3 <= vy2;    vr3 <= vr2;        of3 <= of2;
    end
  end

  // stages 2-3: sine and cosine for each wheel angle
  logic signed [15:0] s0, c0, s1, c1, s2, c2;
  owvm_sincos u_sc0 (.clk(clk), .en(en), .angle(a0), .sin_q15(s0), .cos_q15(c0));
  owvm_sincos u_sc1 (.clk(clk), .en(en), .angle(a1), .sin_q15(s1), .cos_q15(c1));
  owvm_sincos u_sc2 (.clk(clk), .en(en), .angle(a2), .sin_q15(s2), .cos_q15(c2));

  // stages 4-6: per-wheel drive; magnitudes never exceed 32767 so negation is safe
  //   wheel0 =  s0*vx - c0*vy, wheel1 = -s1*vx + c1*vy, wheel2 = -s2*vx - c2*vy
  owvm_wheel u_w0 (
    .clk(clk), .en(en), .coef_x(s0), .coef_y(-c0),
    .vel_x(vx3), .vel_y(vy3), .turn_rate(vr3), .offset_enable(of3),
    .dead_band(dead_band), .drive_limit(drive_limit),
    .speed(wheel0_speed), .reverse(wheel0_reverse)
  );
  owvm_wheel u_w1 (
    .clk(clk), .en(en), .coef_x(-s1), .coef_y(c1),
    .vel_x(vx3), .vel_y(vy3), .turn_rate(vr3), .offset_enable(of3),
    .dead_band(dead_band), .drive_limit(drive_limit),
    .speed(wheel1_speed), .reverse(wheel1_reverse)
  );
  owvm_wheel u_w2 (
    .clk(clk), .en(en), .coef_x(-s2), .coef_y(-c2),
    .vel_x(vx3), .vel_y(vy3), .turn_rate(vr3), .offset_enable(of3),
    .dead_band(dead_band), .drive_limit(drive_limit),
    .speed(wheel2_speed), .reverse(wheel2_reverse)
  );

endmodule
